// File: hdl/am3x4inv_pkg.sv
// Package for the affine 3x4 matrix inverse block.
// Default word format and the adjugate cofactor index table; no dependencies.
package am3x4inv_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_FIELDS      = 12;
    localparam int N_LIN         = 9;

    // adj[e] = +/-(m[p]*m[q] - m[r]*m[s]); indices into the flat row-major 3x4 input
    localparam int ADJ_IDX [N_LIN][4] = '{
        '{5, 10, 9, 6},
        '{1, 10, 9, 2},
        '{1, 6, 5, 2},
        '{4, 10, 8, 6},
        '{0, 10, 8, 2},
        '{0, 6, 4, 2},
        '{4, 9, 8, 5},
        '{0, 9, 8, 1},
        '{0, 5, 4, 1}
    };

    // entries whose cofactor difference is negated
    localparam logic [N_LIN-1:0] ADJ_NEG = 9'b010101010;

endpackage

// File: hdl/affine_3x4_matrix_inverse.sv
// Affine 3x4 matrix inverse, signed fixed point, fully pipelined.
// Depends on am3x4inv_pkg (defaults, cofactor table).
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   twelve input entries, row-major
//  m_axis    out  m_axis_tvalid / m_axis_tready   twelve inverse entries, row-major
//
// One matrix per cycle while the output is not stalled; the pipeline depth is set by
// the restoring divider that yields one quotient bit per stage for each of nine entries.
// Reset (aresetn low, synchronous) clears all stage valid bits only.
// Each stage has its own enable: a stage loads when it is empty or the next
// stage loads, so bubbles close up and a stalled result holds in place.
module affine_3x4_matrix_inverse
    import am3x4inv_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int TDW = ((N_FIELDS * WORD_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // a_row0_col0 .. a_row0_col3, a_row1_col0 .. a_row2_col3, WORD_BITS each, zero pad
    input  logic [TDW-1:0]       s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // inv_row0_col0 .. inv_row0_col3, inv_row1_col0 .. inv_row2_col3, WORD_BITS each
    output logic [TDW-1:0]       m_axis_tdata
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int AW   = 2 * W + 1;
    localparam int DW   = 3 * W + 3;
    localparam int NW   = AW + 2 * F;
    localparam int CW   = ((NW > DW + W) ? NW : DW + W) + 1;
    localparam int SW   = 2 * W + 2;
    localparam int NST  = W + 10;

    localparam int ST_IN  = 0;
    localparam int ST_PRD = 1;
    localparam int ST_ADJ = 2;
    localparam int ST_DPP = 3;
    localparam int ST_DET = 4;
    localparam int ST_DV0 = 5;
    localparam int ST_RND = W + 6;
    localparam int ST_TP  = W + 7;
    localparam int ST_SUM = W + 8;
    localparam int ST_OUT = W + 9;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_axis_tready = en[ST_IN];
    assign m_axis_tvalid = vld_reg[ST_OUT];

    // input stage
    logic signed [W-1:0] m0_reg [N_FIELDS];

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            for (int f = 0; f < N_FIELDS; f++) begin
                m0_reg[f] <= $signed(s_axis_tdata[f*W +: W]);
            end
        end
    end

    // cofactor products
    logic signed [PW-1:0] pa_reg [N_LIN];
    logic signed [PW-1:0] pb_reg [N_LIN];
    logic signed [W-1:0]  t1_reg [3];
    logic signed [W-1:0]  c1_reg [3];

    always_ff @(posedge aclk) begin
        if (en[ST_PRD]) begin
            for (int e = 0; e < N_LIN; e++) begin
                pa_reg[e] <= m0_reg[ADJ_IDX[e][0]] * m0_reg[ADJ_IDX[e][1]];
                pb_reg[e] <= m0_reg[ADJ_IDX[e][2]] * m0_reg[ADJ_IDX[e][3]];
            end
            for (int r = 0; r < 3; r++) begin
                t1_reg[r] <= m0_reg[r*4+3];
                c1_reg[r] <= m0_reg[r];
            end
        end
    end

    // adjugate
    logic signed [AW-1:0] adj2_reg [N_LIN];
    logic signed [W-1:0]  t2_reg [3];
    logic signed [W-1:0]  c2_reg [3];

    always_ff @(posedge aclk) begin
        if (en[ST_ADJ]) begin
            for (int e = 0; e < N_LIN; e++) begin
                if (ADJ_NEG[e]) begin
                    adj2_reg[e] <= $signed({pb_reg[e][PW-1], pb_reg[e]})
                                 - $signed({pa_reg[e][PW-1], pa_reg[e]});
                end else begin
                    adj2_reg[e] <= $signed({pa_reg[e][PW-1], pa_reg[e]})
                                 - $signed({pb_reg[e][PW-1], pb_reg[e]});
                end
            end
            t2_reg <= t1_reg;
            c2_reg <= c1_reg;
        end
    end

    // determinant partial products, adjugate split into high and low halves
    logic signed [AW-1:0] adj3_reg [N_LIN];
    logic signed [W-1:0]  t3_reg [3];
    logic signed [AW-1:0] dl_reg [3];
    logic signed [AW-1:0] dh_reg [3];

    always_ff @(posedge aclk) begin
        if (en[ST_DPP]) begin
            for (int r = 0; r < 3; r++) begin
                dl_reg[r] <= c2_reg[r] * $signed({1'b0, adj2_reg[r*3][W-1:0]});
                dh_reg[r] <= c2_reg[r] * $signed(adj2_reg[r*3][AW-1:W]);
            end
            adj3_reg <= adj2_reg;
            t3_reg   <= t2_reg;
        end
    end

    // determinant, magnitudes and signs
    logic signed [DW-1:0] det_c;
    logic [DW-1:0]        den4_reg;
    logic                 zero4_reg;
    logic [N_LIN-1:0]     neg4_reg;
    logic [NW-1:0]        num4_reg [N_LIN];
    logic signed [W-1:0]  t4_reg [3];
    logic [AW-1:0]        amag_c [N_LIN];

    always_comb begin
        det_c = ((DW'(dh_reg[0]) + DW'(dh_reg[1]) + DW'(dh_reg[2])) <<< W)
              + DW'(dl_reg[0]) + DW'(dl_reg[1]) + DW'(dl_reg[2]);
        for (int e = 0; e < N_LIN; e++) begin
            amag_c[e] = adj3_reg[e][AW-1] ? AW'(-adj3_reg[e]) : AW'(adj3_reg[e]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_DET]) begin
            den4_reg  <= det_c[DW-1] ? DW'(-det_c) : DW'(det_c);
            zero4_reg <= (det_c == '0);
            for (int e = 0; e < N_LIN; e++) begin
                neg4_reg[e] <= adj3_reg[e][AW-1] ^ det_c[DW-1];
                num4_reg[e] <= {amag_c[e], {(2*F){1'b0}}};
            end
            t4_reg <= t3_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [CW-1:0]       dr_reg  [W+1][N_LIN];
    logic [W-1:0]        dq_reg  [W+1][N_LIN];
    logic [DW-1:0]       dd_reg  [W+1];
    logic [N_LIN-1:0]    dn_reg  [W+1];
    logic [N_LIN-1:0]    dof_reg [W+1];
    logic                dz_reg  [W+1];
    logic signed [W-1:0] dt_reg  [W+1][3];

    always_ff @(posedge aclk) begin
        if (en[ST_DV0]) begin
            for (int e = 0; e < N_LIN; e++) begin
                dr_reg[0][e]  <= CW'(num4_reg[e]);
                dq_reg[0][e]  <= '0;
                dof_reg[0][e] <= CW'(num4_reg[e]) >= (CW'(den4_reg) << W);
            end
            dd_reg[0] <= den4_reg;
            dn_reg[0] <= neg4_reg;
            dz_reg[0] <= zero4_reg;
            dt_reg[0] <= t4_reg;
        end
    end

    for (genvar j = 0; j < W; j++) begin : g_div
        localparam int K = W - 1 - j;
        logic [CW:0] trial [N_LIN];

        always_comb begin
            for (int e = 0; e < N_LIN; e++) begin
                trial[e] = {1'b0, dr_reg[j][e]} - {1'b0, CW'(dd_reg[j]) << K};
            end
        end

        always_ff @(posedge aclk) begin
            if (en[ST_DV0+j+1]) begin
                for (int e = 0; e < N_LIN; e++) begin
                    if (!trial[e][CW]) begin
                        dr_reg[j+1][e]    <= trial[e][CW-1:0];
                        dq_reg[j+1][e]    <= dq_reg[j][e] | (W'(1) << K);
                    end else begin
                        dr_reg[j+1][e]    <= dr_reg[j][e];
                        dq_reg[j+1][e]    <= dq_reg[j][e];
                    end
                end
                dd_reg[j+1]  <= dd_reg[j];
                dn_reg[j+1]  <= dn_reg[j];
                dof_reg[j+1] <= dof_reg[j];
                dz_reg[j+1]  <= dz_reg[j];
                dt_reg[j+1]  <= dt_reg[j];
            end
        end
    end

    // round half away, saturate, singular mask
    logic               rb_c  [N_LIN];
    logic [W:0]         q1_c  [N_LIN];
    logic [W:0]         lim_c [N_LIN];
    logic [W-1:0]       inv_c [N_LIN];
    logic signed [W-1:0] inv5_reg [N_LIN];
    logic signed [W-1:0] t5_reg [3];

    always_comb begin
        for (int e = 0; e < N_LIN; e++) begin
            rb_c[e]  = {dr_reg[W][e], 1'b0} >= {1'b0, CW'(dd_reg[W])};
            q1_c[e]  = {1'b0, dq_reg[W][e]} + {{W{1'b0}}, rb_c[e]};
            lim_c[e] = dn_reg[W][e] ? ((W+1)'(1) << (W - 1))
                                    : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
            if (dof_reg[W][e] || (q1_c[e] > lim_c[e])) begin
                q1_c[e] = lim_c[e];
            end
            if (dz_reg[W]) begin
                inv_c[e] = '0;
            end else if (dn_reg[W][e]) begin
                inv_c[e] = -q1_c[e][W-1:0];
            end else begin
                inv_c[e] = q1_c[e][W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_RND]) begin
            for (int e = 0; e < N_LIN; e++) begin
                inv5_reg[e] <= $signed(inv_c[e]);
            end
            t5_reg <= dt_reg[W];
        end
    end

    // translation products
    logic signed [PW-1:0] tp_reg [N_LIN];
    logic signed [W-1:0]  inv6_reg [N_LIN];

    always_ff @(posedge aclk) begin
        if (en[ST_TP]) begin
            for (int e = 0; e < N_LIN; e++) begin
                tp_reg[e] <= inv5_reg[e] * t5_reg[e % 3];
            end
            inv6_reg <= inv5_reg;
        end
    end

    // translation sums
    logic signed [SW-1:0] s_reg [3];
    logic signed [W-1:0]  inv7_reg [N_LIN];

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            for (int r = 0; r < 3; r++) begin
                s_reg[r] <= SW'(tp_reg[r*3]) + SW'(tp_reg[r*3+1]) + SW'(tp_reg[r*3+2]);
            end
            inv7_reg <= inv6_reg;
        end
    end

    // negate, round by 2^F, saturate
    logic signed [SW:0] ns_c  [3];
    logic [SW:0]        nm_c  [3];
    logic [SW:0]        nq_c  [3];
    logic [SW:0]        nl_c  [3];
    logic [W-1:0]       tr_c  [3];
    logic [W-1:0]       out_reg [N_FIELDS];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            ns_c[r] = -(SW+1)'(s_reg[r]);
            nm_c[r] = ns_c[r][SW] ? (SW+1)'(-ns_c[r]) : (SW+1)'(ns_c[r]);
            nq_c[r] = (nm_c[r] + ((SW+1)'(1) << (F - 1))) >> F;
            nl_c[r] = ns_c[r][SW] ? ((SW+1)'(1) << (W - 1))
                                  : (((SW+1)'(1) << (W - 1)) - (SW+1)'(1));
            if (nq_c[r] > nl_c[r]) begin
                nq_c[r] = nl_c[r];
            end
            tr_c[r] = ns_c[r][SW] ? -nq_c[r][W-1:0] : nq_c[r][W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    out_reg[r*4+c] <= inv7_reg[r*3+c];
                end
                out_reg[r*4+3] <= tr_c[r];
            end
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int f = 0; f < N_FIELDS; f++) begin
            m_axis_tdata[f*W +: W] = out_reg[f];
        end
    end

    logic inv_nz;
    assign inv_nz = (inv5_reg[0] != '0) || (inv5_reg[1] != '0) || (inv5_reg[2] != '0)
                 || (inv5_reg[3] != '0) || (inv5_reg[4] != '0) || (inv5_reg[5] != '0)
                 || (inv5_reg[6] != '0) || (inv5_reg[7] != '0) || (inv5_reg[8] != '0);

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (en[ST_RND] && vld_reg[ST_RND-1] && dz_reg[W]) |=> !inv_nz)
        else $error("singular matrix gave nonzero inverse");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_RND-1] && !dz_reg[W] && !dof_reg[W][0])
            |-> (dr_reg[W][0] < CW'(dd_reg[W])))
        else $error("divider remainder not below divisor");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[ST_OUT] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_OUT] && !m_axis_tready) |=> (vld_reg[ST_OUT] && $stable(out_reg[3])))
        else $error("stalled result changed");

endmodule

// File: sim/affine_3x4_matrix_inverse_chk.sv
`timescale 1ns / 100ps
// Checker for the affine 3x4 matrix inverse: watches both stream channels,
// predicts each inverse exactly and compares field by field. Uses am3x4inv_pkg.
module affine_3x4_matrix_inverse_chk
    import am3x4inv_pkg::*;
#(
    parameter int TDW = 384
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    input  logic           s_axis_tready,
    input  logic [TDW-1:0] s_axis_tdata,
    input  logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    input  logic [TDW-1:0] m_axis_tdata,
    output int             errors,
    output int             pending,
    output int             inverses_seen
);

    localparam int WB = WORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;

    typedef logic signed [191:0] wide_t;

    logic [TDW-1:0] inverse_q[$];

    function automatic logic [WB-1:0] round_div_sat(wide_t num, wide_t den);
        logic  neg;
        wide_t n, d, q, r, lim;
        if (den == 0) return '0;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = wide_t'($unsigned(n) / $unsigned(d));
        r = wide_t'($unsigned(n) % $unsigned(d));
        if ((r <<< 1) >= d) q = q + 1;
        lim = (wide_t'(1) <<< (WB - 1)) - (neg ? 0 : 1);
        if (q > lim) q = lim;
        if (neg) q = -q;
        return q[WB-1:0];
    endfunction

    function automatic logic [TDW-1:0] predict_inverse(logic [TDW-1:0] d);
        wide_t           m[N_FIELDS];
        wide_t           det, adj, s;
        logic [WB-1:0]   lin[N_LIN];
        logic [TDW-1:0]  res;
        res = '0;
        for (int k = 0; k < N_FIELDS; k++) m[k] = wide_t'($signed(d[k*WB +: WB]));
        det = m[0]*m[5]*m[10] + m[4]*m[9]*m[2] + m[8]*m[1]*m[6]
            - m[8]*m[5]*m[2] - m[4]*m[1]*m[10] - m[0]*m[9]*m[6];
        if (det == 0) return res;
        for (int e = 0; e < N_LIN; e++) begin
            adj = m[ADJ_IDX[e][0]] * m[ADJ_IDX[e][1]] - m[ADJ_IDX[e][2]] * m[ADJ_IDX[e][3]];
            if (ADJ_NEG[e]) adj = -adj;
            lin[e] = round_div_sat(adj <<< (2 * FB), det);
        end
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int j = 0; j < 3; j++) begin
                s = s + m[j*4+3] * wide_t'($signed(lin[i*3+j]));
                res[(i*4+j)*WB +: WB] = lin[i*3+j];
            end
            res[(i*4+3)*WB +: WB] = round_div_sat(-s, wide_t'(1) <<< FB);
        end
        return res;
    endfunction

    initial begin
        errors = 0;
        inverses_seen = 0;
    end

    assign pending = inverse_q.size();

    always @(posedge aclk) begin
        logic [TDW-1:0] exp_inv;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            inverse_q.push_back(predict_inverse(s_axis_tdata));
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            inverses_seen <= inverses_seen + 1;
            if (inverse_q.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10) $display("ERROR: unexpected result transfer %h", m_axis_tdata);
            end else begin
                exp_inv = inverse_q.pop_front();
                for (int k = 0; k < N_FIELDS; k++)
                    if (exp_inv[k*WB +: WB] !== m_axis_tdata[k*WB +: WB]) begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("ERROR: result %0d field %0d exp %h got %h",
                                     inverses_seen, k, exp_inv[k*WB +: WB],
                                     m_axis_tdata[k*WB +: WB]);
                    end
            end
        end
    end

endmodule

// File: sim/affine_3x4_matrix_inverse_tb.sv
`timescale 1ns / 100ps
// Testbench top for affine_3x4_matrix_inverse: clock, reset, bursty stimulus,
// receiver backpressure and verdict. Uses am3x4inv_pkg and the checker module.
module affine_3x4_matrix_inverse_tb;
    import am3x4inv_pkg::*;

    localparam int TDW       = 384;
    localparam int WB        = WORD_BITS_DEF;
    localparam int ONE       = 1 << FRAC_BITS_DEF;
    localparam int N_RANDOM  = 630;
    localparam int LIMIT     = 300000;
    localparam int HOLD_LEN  = 400;

    typedef enum int { MK_WELL, MK_SMALL, MK_FULL, MK_SINGULAR } mat_kind_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [TDW-1:0] m_axis_tdata;

    int  errors, pending, inverses_seen;
    int  cycles = 0;
    int  sent = 0;
    bit  hold_go = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_cnt = 0;

    always #6 aclk = ~aclk;

    affine_3x4_matrix_inverse uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    affine_3x4_matrix_inverse_chk #(.TDW(TDW)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .errors(errors), .pending(pending), .inverses_seen(inverses_seen)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall pattern, one long hold-off once requested
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
        end else if ((cycles / 500) % 3 == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [TDW-1:0] pack(int v[N_FIELDS]);
        logic [TDW-1:0] d;
        d = '0;
        for (int k = 0; k < N_FIELDS; k++) d[k*WB +: WB] = v[k];
        return d;
    endfunction

    function automatic logic [TDW-1:0] rand_matrix(mat_kind_t kind);
        int v[N_FIELDS];
        for (int k = 0; k < N_FIELDS; k++) begin
            case (kind)
                MK_WELL: begin
                    if (k % 4 == 3) v[k] = ($urandom_range(0, 3) == 0) ? $urandom
                                          : $signed($urandom_range(0, 64 * ONE)) - 32 * ONE;
                    else if (k % 5 == 0) v[k] = ($urandom_range(0, 1) ? 1 : -1)
                                          * $signed($urandom_range(ONE / 2, 4 * ONE));
                    else v[k] = $signed($urandom_range(0, ONE / 2)) - ONE / 4;
                end
                MK_SMALL: v[k] = $signed($urandom_range(0, 64)) - 32;
                default:  v[k] = $urandom;
            endcase
        end
        if (kind == MK_SINGULAR) begin
            if ($urandom_range(0, 1)) for (int c = 0; c < 3; c++) v[8 + c] = v[c];
            else for (int c = 0; c < 3; c++) v[4 + c] = 0;
        end
        return pack(v);
    endfunction

    task automatic send_item(logic [TDW-1:0] d);
        bit acc;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            acc = s_axis_tready;
            @(posedge aclk);
        end while (!acc);
        sent++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_directed();
        int v[N_FIELDS];
        int mx = 32'h7fffffff;
        int mn = 32'h80000000;
        v = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};
        send_item(pack(v));
        v = '{ONE, 0, 0, mx, 0, ONE, 0, mn, 0, 0, ONE, -1};
        send_item(pack(v));
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_item(pack(v));
        v = '{mx, 0, 0, 1, 0, mx, 0, 1, 0, 0, mx, 1};
        send_item(pack(v));
        v = '{mn, 0, 0, mx, 0, mn, 0, mx, 0, 0, mn, mx};
        send_item(pack(v));
        v = '{1, 0, 0, ONE, 0, 1, 0, -ONE, 0, 0, 1, ONE};
        send_item(pack(v));
        v = '{-1, 0, 0, mn, 0, -1, 0, mx, 0, 0, -1, 1};
        send_item(pack(v));
        v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx};
        send_item(pack(v));
        v = '{mn, mx, mn, mn, mx, mn, mx, mx, mn, mn, mx, mn};
        send_item(pack(v));
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_item(pack(v));
        v = '{0, ONE, 0, 3 * ONE, ONE, 0, 0, -5 * ONE, 0, 0, -ONE, ONE / 2};
        send_item(pack(v));
        v = '{2 * ONE, 0, 0, ONE, 0, 3 * ONE, 0, ONE, 0, 0, 5 * ONE, ONE};
        send_item(pack(v));
        v = '{ONE, 2 * ONE, 3 * ONE, 0, 4 * ONE, 5 * ONE, 6 * ONE, 0,
              7 * ONE, 8 * ONE, 9 * ONE, 0};
        send_item(pack(v));
        v = '{3, 1, 0, 7, 1, 3, 0, -7, 0, 0, 2, 5};
        send_item(pack(v));
        v = '{ONE / 3, 0, 0, 0, 0, ONE / 7, 0, 0, 0, 0, -ONE / 9, 0};
        send_item(pack(v));
        send_item(rand_matrix(MK_SINGULAR));
        send_item(rand_matrix(MK_SINGULAR));
        idle_gap(1);
    endtask

    initial begin
        int r;
        mat_kind_t kind;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_directed();
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            kind = (r < 55) ? MK_WELL : (r < 70) ? MK_SMALL : (r < 88) ? MK_FULL : MK_SINGULAR;
            send_item(rand_matrix(kind));
            if (n == 250) hold_go <= 1'b1;
            if (n == 450) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end else if ($urandom_range(0, 7) == 0) begin
                idle_gap($urandom_range(1, 12));
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (WB + 20) @(posedge aclk);
        $display("Sent %0d matrices (directed extremes, singular, saturating, random)", sent);
        $display("Received %0d inverses under bursty input and random backpressure",
                 inverses_seen);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: affine_3x4_matrix_inverse.f
hdl/am3x4inv_pkg.sv
hdl/affine_3x4_matrix_inverse.sv
sim/affine_3x4_matrix_inverse_chk.sv
sim/affine_3x4_matrix_inverse_tb.sv
